// ===== design/adlb_pkg.sv =====
// ----------------------------------------------------------------------
// Line breaker package
// Character codes, phase encoding and the records that travel between
// the line breaker's register port, scan core and result queue.
// ----------------------------------------------------------------------
package adlb_pkg;

  localparam int TAB_COLUMNS = 4;
  // Counters are as wide as the line_length and line_index fields.
  localparam int COUNT_BITS  = 16;

  localparam logic [7:0] ESC_CHAR   = 8'h1B;
  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] TAB_CHAR   = 8'h09;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] GT_CHAR    = 8'h3E;
  localparam logic [7:0] LBRK_CHAR  = 8'h5B;
  localparam logic [7:0] SEMI_CHAR  = 8'h3B;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NINE_CHAR  = 8'h39;

  localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;
  localparam logic [8:0] MIN_WIDTH        = 9'd2;

  localparam int         ADDR_BITS      = 3;
  localparam logic [0:0] REG_LINE_WIDTH = 1'b0;

  typedef logic [COUNT_BITS-1:0] count_t;
  localparam count_t COUNT_MAX = '1;

  typedef enum logic [2:0] {
    PH_SCAN,
    PH_FULL,
    PH_TESC,
    PH_AFTER,
    PH_CR
  } phase_t;

  typedef struct packed {
    logic [8:0] budget;
    phase_t     phase;
    logic       esc;
    logic       trail;
    logic       quote;
    logic       tab;
    logic [7:0] first;
    count_t     bcnt;
    count_t     lcnt;
  } line_state_t;

  typedef struct packed {
    logic [15:0] line_length;
    logic [15:0] line_index;
    logic        has_tab;
    logic        quote_after;
    logic        final_line;
  } line_word_t;

  // Up to two finished lines pushed into the result queue per byte.
  typedef struct packed {
    logic [1:0] n;
    line_word_t w0;
    line_word_t w1;
  } push_t;

  typedef struct packed {
    line_state_t st;
    push_t       push;
  } step_t;

endpackage

// ===== design/adlb_cfg.sv =====
// ----------------------------------------------------------------------
// Line breaker register port
// APB-style slave holding the line width register.
// ----------------------------------------------------------------------
module adlb_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adlb_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [7:0]                    line_width
);
  import adlb_pkg::*;

  logic [7:0] width_r;
  logic [7:0] width_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_LINE_WIDTH);

  always_comb begin
    width_nxt = width_r;
    if (wr_en) begin
      width_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= LINE_WIDTH_RESET;
    end else begin
      width_r <= width_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LINE_WIDTH: prdata = {24'd0, width_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign line_width = width_r;

endmodule

// ===== design/adlb_core.sv =====
// ----------------------------------------------------------------------
// Line breaker scan core
// Registers one text word, then updates the line state and produces the
// finished lines it causes in a single pass.
// ----------------------------------------------------------------------
module adlb_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      line_width,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_text_byte,
  input  logic            in_end_of_text,
  input  logic            room,
  output adlb_pkg::push_t push
);
  import adlb_pkg::*;

  logic        in_v_r;
  logic [7:0]  byte_r;
  logic        eot_r;
  logic        in_v_nxt;
  logic        proc;
  logic        accept;
  logic [8:0]  width_eff;
  line_state_t st_r;
  line_state_t st_nxt;
  step_t       step;

  function automatic logic is_code(logic [7:0] b);
    return (b == LBRK_CHAR) || (b == SEMI_CHAR) || (b >= ZERO_CHAR && b <= NINE_CHAR);
  endfunction

  function automatic line_state_t take(line_state_t s, logic [7:0] b);
    line_state_t r;
    r = s;
    if (s.bcnt == '0) begin
      r.first = b;
    end else if (s.bcnt == count_t'(1) && b == SPACE_CHAR &&
                 (s.first == COLON_CHAR || s.first == GT_CHAR)) begin
      r.quote = 1'b1;
    end
    if (s.bcnt != COUNT_MAX) begin
      r.bcnt = s.bcnt + count_t'(1);
    end
    return r;
  endfunction

  function automatic line_state_t start_line(line_state_t s, logic [8:0] w);
    line_state_t r;
    r        = s;
    r.bcnt   = '0;
    r.budget = w;
    r.phase  = PH_SCAN;
    r.esc    = 1'b0;
    r.trail  = 1'b0;
    r.tab    = 1'b0;
    r.first  = 8'd0;
    return r;
  endfunction

  function automatic step_t emit(step_t x, logic fin, logic [8:0] w);
    step_t      r;
    line_word_t lw;
    r              = x;
    lw.line_length = x.st.bcnt;
    lw.line_index  = x.st.lcnt;
    lw.has_tab     = x.st.tab;
    lw.quote_after = x.st.quote;
    lw.final_line  = fin;
    if (x.push.n == 2'd0) begin
      r.push.w0 = lw;
      r.push.n  = 2'd1;
    end else if (x.push.n == 2'd1) begin
      r.push.w1 = lw;
      r.push.n  = 2'd2;
    end
    if (fin) begin
      r.st.quote = 1'b0;
      r.st.lcnt  = '0;
    end else if (x.st.lcnt != COUNT_MAX) begin
      r.st.lcnt = x.st.lcnt + count_t'(1);
    end
    r.st = start_line(r.st, w);
    return r;
  endfunction

  function automatic step_t full_reached(step_t x, logic eot, logic [8:0] w);
    step_t r;
    r = x;
    if (eot) begin
      r = emit(r, 1'b1, w);
    end else begin
      r.st.phase = PH_FULL;
    end
    return r;
  endfunction

  // Columns a tab advances from the current position to the next stop.
  function automatic logic [8:0] tab_adv(logic [8:0] budget, logic [8:0] w);
    logic [8:0] used;
    used = w - budget;
    return 9'(TAB_COLUMNS) - (used % 9'(TAB_COLUMNS));
  endfunction

  // Takes the byte into the current line; the caller has already made
  // room for a tab or a pair that would not fit.
  function automatic step_t scan_take(step_t x, logic [7:0] b, logic eot, logic [8:0] w);
    step_t      r;
    logic [8:0] adv;
    r   = x;
    adv = tab_adv(x.st.budget, w);
    if (x.st.trail) begin
      r.st       = take(r.st, b);
      r.st.trail = 1'b0;
      if (r.st.budget == 9'd0) begin
        r = full_reached(r, eot, w);
      end else if (eot) begin
        r = emit(r, 1'b1, w);
      end
    end else if (b == LF_CHAR) begin
      r.st       = take(r.st, b);
      r.st.quote = 1'b0;
      r          = emit(r, eot, w);
    end else if (b == ESC_CHAR) begin
      r.st     = take(r.st, b);
      r.st.esc = 1'b1;
      if (eot) begin
        r = emit(r, 1'b1, w);
      end
    end else if (x.st.esc) begin
      r.st = take(r.st, b);
      if (!is_code(b)) begin
        r.st.esc = 1'b0;
      end
      if (eot) begin
        r = emit(r, 1'b1, w);
      end
    end else if (b == TAB_CHAR) begin
      r.st        = take(r.st, b);
      r.st.tab    = 1'b1;
      r.st.budget = (adv >= x.st.budget) ? 9'd0 : x.st.budget - adv;
      if (r.st.budget == 9'd0) begin
        r = full_reached(r, eot, w);
      end else if (eot) begin
        r = emit(r, 1'b1, w);
      end
    end else if (b[7]) begin
      r.st        = take(r.st, b);
      r.st.budget = (x.st.budget >= 9'd2) ? x.st.budget - 9'd2 : 9'd0;
      r.st.trail  = 1'b1;
      if (eot) begin
        r = emit(r, 1'b1, w);
      end
    end else begin
      r.st        = take(r.st, b);
      r.st.budget = (x.st.budget != 9'd0) ? x.st.budget - 9'd1 : 9'd0;
      if (r.st.budget == 9'd0) begin
        r = full_reached(r, eot, w);
      end else if (eot) begin
        r = emit(r, 1'b1, w);
      end
    end
    return r;
  endfunction

  // A tab or a double-width pair that does not fit closes the line first.
  function automatic step_t scan(step_t x, logic [7:0] b, logic eot, logic force_in,
                                 logic [8:0] w);
    step_t r;
    logic  retry;
    r     = x;
    retry = 1'b0;
    if (!x.st.trail && b != LF_CHAR && b != ESC_CHAR && !x.st.esc) begin
      if (b == TAB_CHAR) begin
        retry = (tab_adv(x.st.budget, w) > x.st.budget) && !force_in &&
                (x.st.budget != w);
      end else if (b[7]) begin
        retry = (x.st.budget < 9'd2) && !force_in;
      end
    end
    if (retry) begin
      r = emit(r, 1'b0, w);
    end
    r = scan_take(r, b, eot, w);
    return r;
  endfunction

  assign width_eff = (line_width < 8'd2) ? MIN_WIDTH : {1'b0, line_width};
  assign proc      = in_v_r && room;
  assign in_stall  = in_v_r && !room;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    step        = '0;
    step.st     = st_r;
    unique case (st_r.phase) inside
      PH_FULL, PH_AFTER: begin
        if (byte_r == ESC_CHAR && st_r.phase == PH_FULL) begin
          step.st       = take(step.st, byte_r);
          step.st.phase = PH_TESC;
          if (eot_r) begin
            step = emit(step, 1'b1, width_eff);
          end
        end else if (byte_r == LF_CHAR) begin
          step.st       = take(step.st, byte_r);
          step.st.quote = 1'b0;
          step          = emit(step, eot_r, width_eff);
        end else if (byte_r == CR_CHAR && !eot_r) begin
          step.st.phase = PH_CR;
        end else begin
          step = emit(step, 1'b0, width_eff);
          step = scan(step, byte_r, eot_r, 1'b0, width_eff);
        end
      end
      PH_TESC: begin
        step.st = take(step.st, byte_r);
        if (!is_code(byte_r)) begin
          step.st.phase = PH_AFTER;
        end
        if (eot_r) begin
          step = emit(step, 1'b1, width_eff);
        end
      end
      PH_CR: begin
        if (byte_r == LF_CHAR) begin
          step.st       = take(step.st, CR_CHAR);
          step.st       = take(step.st, byte_r);
          step.st.quote = 1'b0;
          step          = emit(step, eot_r, width_eff);
        end else begin
          // The lone carriage return opens the next line as a plain byte.
          step = emit(step, 1'b0, width_eff);
          step = scan(step, CR_CHAR, 1'b0, 1'b0, width_eff);
          step = scan(step, byte_r, eot_r, eot_r, width_eff);
        end
      end
      default: begin
        step = scan(step, byte_r, eot_r, 1'b0, width_eff);
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    if (proc) begin
      st_nxt = step.st;
    end
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (proc) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    push   = step.push;
    if (!proc) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      st_r   <= '{budget: {1'b0, LINE_WIDTH_RESET}, phase: PH_SCAN, default: '0};
    end else begin
      in_v_r <= in_v_nxt;
      st_r   <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_text_byte;
      eot_r  <= in_end_of_text;
    end
  end

endmodule

// ===== design/adlb_outq.sv =====
// ----------------------------------------------------------------------
// Line breaker result queue
// Small queue that takes up to two finished lines per cycle and hands
// them out one word at a time.
// ----------------------------------------------------------------------
module adlb_outq #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  adlb_pkg::push_t      push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output adlb_pkg::line_word_t out_word
);
  import adlb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  line_word_t    mem_r [DEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] wr_nxt;
  logic [PW-1:0] rd_nxt;
  logic [CW-1:0] cnt_nxt;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Room for a full pair of lines is kept before the core takes a word.
  assign room      = (cnt_r <= CW'(DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_word  = mem_r[rd_r];

  always_comb begin
    case (push.n)
      2'd1:    wr_nxt = ptr_inc(wr_r);
      2'd2:    wr_nxt = ptr_inc(ptr_inc(wr_r));
      default: wr_nxt = wr_r;
    endcase
    rd_nxt  = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_r] <= push.w0;
    end
    if (push.n == 2'd2) begin
      mem_r[ptr_inc(wr_r)] <= push.w1;
    end
  end

endmodule

// ===== design/ansi_dbcs_line_breaker.sv =====
// ----------------------------------------------------------------------
// Display line breaker
// Splits a text byte stream into display lines of a set column width.
// ----------------------------------------------------------------------
// The input channel takes one text word per cycle: the byte and a flag
// that marks the last byte of a text. The result channel gives one word
// per finished line: its byte length, its line number, whether it holds
// a tab, the quote state it leaves and whether it ends the text.
// The line width register lies at address 0 of the register port.
//
// A byte is registered on acceptance and processed once the result queue
// has room; the lines it finishes are written to the queue for out_valid.
// One byte is taken every cycle; a byte may finish two lines, and the
// result queue (OUT_DEPTH words) accepts a byte only while two free
// entries remain, so sustained rate is set by how fast lines drain.
// When the receiver stalls, finished lines wait in the queue and the
// input stalls once the queue is nearly full.
// Reset empties the queue, sets the width to 80 columns and starts a
// new text at line 0. After a final line the next byte starts a new text.
module ansi_dbcs_line_breaker #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [adlb_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_text_byte,
  input  logic                           in_end_of_text,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_line_length,
  output logic [15:0]                    out_line_index,
  output logic                           out_has_tab,
  output logic                           out_quote_after,
  output logic                           out_final_line
);
  import adlb_pkg::*;

  logic [7:0] line_width;
  logic       room;
  push_t      push;
  line_word_t out_word;

  adlb_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .line_width (line_width)
  );

  adlb_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .line_width     (line_width),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .room           (room),
    .push           (push)
  );

  adlb_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_line_length = out_word.line_length;
  assign out_line_index  = out_word.line_index;
  assign out_has_tab     = out_word.has_tab;
  assign out_quote_after = out_word.quote_after;
  assign out_final_line  = out_word.final_line;

endmodule

// ===== design/adlb_checker.sv =====
// ----------------------------------------------------------------------
// Line breaker port checker
// Watches the top-level ports for reset, stall hold and ordering of the finished lines.
// ----------------------------------------------------------------------
module adlb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [adlb_pkg::ADDR_BITS-1:0] paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata,
  input logic                           pready,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [7:0]                     in_text_byte,
  input logic                           in_end_of_text,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [15:0]                    out_line_length,
  input logic [15:0]                    out_line_index,
  input logic                           out_has_tab,
  input logic                           out_quote_after,
  input logic                           out_final_line
);

  logic out_take;

  assign out_take = out_valid && !out_stall;

  // Reset leaves no finished line waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_length) &&
                               $stable(out_line_index) && $stable(out_final_line))
    else $error("stalled result word changed");

  // Lines of one text are numbered one after another.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !out_final_line && out_line_index != 16'hFFFF) ##1 out_valid |->
      out_line_index == $past(out_line_index) + 16'd1)
    else $error("line number did not advance by one");

  // A new text starts at line zero.
  a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_final_line) ##1 out_valid |-> out_line_index == 16'd0)
    else $error("line number did not restart after the final line");

endmodule

bind ansi_dbcs_line_breaker adlb_checker u_adlb_checker (.*);

// ===== test/ansi_dbcs_line_breaker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------
// Display line breaker testbench
// Streams text words into the line breaker and checks each finished line
// against a cycle-free model of the column, escape, tab, double-byte and
// quote rules. Width register changes happen only while the block is idle.
// Also covered: four idling mixes on the two channels.
// ----------------------------------------------------------------------
module ansi_dbcs_line_breaker_tb;
  import adlb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int SEG_WORDS      = 120;
  localparam logic [ADDR_BITS-1:0] WIDTH_ADDR = ADDR_BITS'(4 * REG_LINE_WIDTH);

  typedef struct packed {
    bit [7:0] b;
    bit       last;
  } text_word_t;

  // Predicts the finished lines and holds those not yet seen.
  class line_scoreboard;
    bit [7:0]   width_reg;
    bit [8:0]   budget;
    phase_t     ph;
    bit         esc_on;
    bit         trail_due;
    bit         quote_on;
    bit         tab_in_line;
    bit [7:0]   first_byte;
    count_t     len_cnt;
    count_t     line_cnt;
    int         lines_this_word;
    line_word_t lines_due[$];
    int         n_fail;
    int         n_checked;
    int         n_words;

    function new();
      width_reg = LINE_WIDTH_RESET;
      quote_on  = 1'b0;
      line_cnt  = '0;
      start_line();
    endfunction

    function bit [8:0] cols();
      return (width_reg < 8'd2) ? MIN_WIDTH : {1'b0, width_reg};
    endfunction

    function bit is_code(bit [7:0] b);
      return b == LBRK_CHAR || b == SEMI_CHAR || (b >= ZERO_CHAR && b <= NINE_CHAR);
    endfunction

    function void start_line();
      len_cnt     = '0;
      budget      = cols();
      ph          = PH_SCAN;
      esc_on      = 1'b0;
      trail_due   = 1'b0;
      tab_in_line = 1'b0;
      first_byte  = 8'd0;
    endfunction

    function void take(bit [7:0] b);
      if (len_cnt == 0) begin
        first_byte = b;
      end else if (len_cnt == 1 && b == SPACE_CHAR &&
                   (first_byte == COLON_CHAR || first_byte == GT_CHAR)) begin
        quote_on = 1'b1;
      end
      if (len_cnt != COUNT_MAX) len_cnt++;
    endfunction

    function void close_line(bit fin);
      line_word_t w;
      if (lines_this_word < 2) begin
        w.line_length = len_cnt;
        w.line_index  = line_cnt;
        w.has_tab     = tab_in_line;
        w.quote_after = quote_on;
        w.final_line  = fin;
        lines_due.push_back(w);
      end
      lines_this_word++;
      if (fin) begin
        quote_on = 1'b0;
        line_cnt = '0;
      end else if (line_cnt != COUNT_MAX) begin
        line_cnt++;
      end
      start_line();
    endfunction

    function void line_full(bit eot);
      if (eot) close_line(1'b1);
      else ph = PH_FULL;
    endfunction

    // A tab or lead byte that does not fit closes the line and is then
    // retried on the fresh one, where it always fits.
    function void scan(bit [7:0] b, bit eot, bit fit_anyway);
      bit [8:0] w;
      bit [8:0] used;
      int       adv;
      bit       again;
      w = cols();
      again = 1'b1;
      while (again) begin
        again = 1'b0;
        if (trail_due) begin
          take(b);
          trail_due = 1'b0;
          if (budget == 0) line_full(eot);
          else if (eot) close_line(1'b1);
        end else if (b == LF_CHAR) begin
          take(b);
          quote_on = 1'b0;
          close_line(eot);
        end else if (b == ESC_CHAR) begin
          take(b);
          esc_on = 1'b1;
          if (eot) close_line(1'b1);
        end else if (esc_on) begin
          take(b);
          if (!is_code(b)) esc_on = 1'b0;
          if (eot) close_line(1'b1);
        end else if (b == TAB_CHAR) begin
          // After a width change the budget may exceed the width; the
          // position then wraps within nine bits.
          used = w - budget;
          adv = TAB_COLUMNS - int'(used) % TAB_COLUMNS;
          if (adv > int'(budget) && !fit_anyway && budget != w) begin
            close_line(1'b0);
            again = 1'b1;
          end else begin
            take(b);
            tab_in_line = 1'b1;
            budget = (adv >= int'(budget)) ? 9'd0 : budget - 9'(adv);
            if (budget == 0) line_full(eot);
            else if (eot) close_line(1'b1);
          end
        end else if (b[7]) begin
          if (budget < 2 && !fit_anyway) begin
            close_line(1'b0);
            again = 1'b1;
          end else begin
            take(b);
            budget = (budget >= 2) ? budget - 9'd2 : 9'd0;
            trail_due = 1'b1;
            if (eot) close_line(1'b1);
          end
        end else begin
          take(b);
          budget = (budget != 0) ? budget - 9'd1 : 9'd0;
          if (budget == 0) line_full(eot);
          else if (eot) close_line(1'b1);
        end
      end
    endfunction

    function void note_word(bit [7:0] b, bit eot);
      lines_this_word = 0;
      n_words++;
      case (ph)
        PH_FULL, PH_AFTER: begin
          if (b == ESC_CHAR && ph == PH_FULL) begin
            take(b);
            ph = PH_TESC;
            if (eot) close_line(1'b1);
          end else if (b == LF_CHAR) begin
            take(b);
            quote_on = 1'b0;
            close_line(eot);
          end else if (b == CR_CHAR && !eot) begin
            ph = PH_CR;
          end else begin
            close_line(1'b0);
            scan(b, eot, 1'b0);
          end
        end
        PH_TESC: begin
          take(b);
          if (!is_code(b)) ph = PH_AFTER;
          if (eot) close_line(1'b1);
        end
        PH_CR: begin
          if (b == LF_CHAR) begin
            take(CR_CHAR);
            take(b);
            quote_on = 1'b0;
            close_line(eot);
          end else begin
            // The held carriage return opens the next line as a plain byte.
            close_line(1'b0);
            scan(CR_CHAR, 1'b0, 1'b0);
            scan(b, eot, eot);
          end
        end
        default: scan(b, eot, 1'b0);
      endcase
    endfunction

    function void note_fail(string msg);
      n_fail++;
      if (n_fail <= 10) $display("%s", msg);
    endfunction

    function void check_line(line_word_t got);
      line_word_t want;
      n_checked++;
      if (lines_due.size() == 0) begin
        note_fail($sformatf("Unexpected line: length %0d index %0d",
                            got.line_length, got.line_index));
        return;
      end
      want = lines_due.pop_front();
      if (got.line_length != want.line_length || got.line_index != want.line_index ||
          got.has_tab != want.has_tab || got.quote_after != want.quote_after ||
          got.final_line != want.final_line) begin
        note_fail($sformatf({"Line %0d mismatch (expected/actual): length %0d/%0d ",
                             "index %0d/%0d tab %0d/%0d quote %0d/%0d final %0d/%0d"},
                            n_checked, want.line_length, got.line_length,
                            want.line_index, got.line_index, want.has_tab, got.has_tab,
                            want.quote_after, got.quote_after,
                            want.final_line, got.final_line));
      end
    endfunction

    function void check_readback(bit [7:0] got);
      if (got != width_reg)
        note_fail($sformatf("Width readback mismatch: expected %0d, actual %0d",
                            width_reg, got));
    endfunction
  endclass

  bit          clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_text_byte;
  logic        in_end_of_text;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_line_length;
  logic [15:0] out_line_index;
  logic        out_has_tab;
  logic        out_quote_after;
  logic        out_final_line;

  line_scoreboard sb;
  text_word_t     text_q[$];
  line_word_t     seen_line;
  bit             word_moved;
  int             idle_cycles;
  int             src_idle_pct;
  int             snk_stall_pct;
  int             n_widths;

  ansi_dbcs_line_breaker u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_length (out_line_length),
    .out_line_index  (out_line_index),
    .out_has_tab     (out_has_tab),
    .out_quote_after (out_quote_after),
    .out_final_line  (out_final_line)
  );

  always begin
    clk = 1'b0;
    #1.0;
    clk = 1'b1;
    #1.0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  // Results are checked before the word of the same edge is predicted;
  // a word's lines cannot appear at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n) begin
      word_moved = 1'b0;
      if (out_valid && !out_stall) begin
        seen_line.line_length = out_line_length;
        seen_line.line_index  = out_line_index;
        seen_line.has_tab     = out_has_tab;
        seen_line.quote_after = out_quote_after;
        seen_line.final_line  = out_final_line;
        sb.check_line(seen_line);
        word_moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.note_word(in_text_byte, in_end_of_text);
        word_moved = 1'b1;
      end
      idle_cycles = word_moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("No word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // All driving tasks start and end just after a falling edge.
  task automatic send_byte(input bit [7:0] b, input bit eot);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_str(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]), close && i == s.len() - 1);
  endtask

  task automatic drain_lines(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.lines_due.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic cfg_write(input bit [7:0] v);
    // A word that ends no line may still be in flight after the last result.
    drain_lines(SETTLE_CYCLES);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WIDTH_ADDR;
    pwdata  <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.width_reg = v;
    n_widths++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_readback(prdata[7:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function void push_byte(bit [7:0] b);
    text_q.push_back('{b: b, last: 1'b0});
  endfunction

  // Mostly well-formed text with random content, plus raw byte noise and
  // escape sequences with arbitrary terminators.
  function void make_text();
    int n_tokens;
    n_tokens = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    repeat (n_tokens) begin
      case ($urandom_range(99)) inside
        [0:34]: push_byte(8'($urandom_range(8'h20, 8'h7E)));
        [35:44]: begin
          push_byte($urandom_range(1) ? COLON_CHAR : GT_CHAR);
          push_byte(SPACE_CHAR);
        end
        [45:52]: push_byte(TAB_CHAR);
        [53:60]: begin
          if ($urandom_range(1)) push_byte(CR_CHAR);
          push_byte(LF_CHAR);
        end
        [61:66]: push_byte(CR_CHAR);
        [67:74]: begin
          push_byte(ESC_CHAR);
          push_byte(LBRK_CHAR);
          repeat ($urandom_range(3))
            push_byte($urandom_range(3) == 0 ? SEMI_CHAR
                                             : 8'($urandom_range(ZERO_CHAR, NINE_CHAR)));
          push_byte($urandom_range(2) == 0 ? 8'($urandom_range(255)) : 8'h6D);
        end
        [75:84]: begin
          push_byte(8'($urandom_range(8'h80, 8'hFF)));
          push_byte(8'($urandom_range(255)));
        end
        default: push_byte(8'($urandom_range(255)));
      endcase
    end
    text_q[text_q.size() - 1].last = 1'b1;
  endfunction

  function bit [7:0] pick_width(int seg);
    case (seg)
      0: return 8'd2;
      5: return 8'd255;
      10: return 8'd0;
      13: return 8'd1;
      default: return ($urandom_range(3) == 0) ? 8'($urandom_range(13, 255))
                                                : 8'($urandom_range(2, 12));
    endcase
  endfunction

  // A text may run on across a segment boundary, so width changes land
  // in the middle of lines too.
  task automatic run_segment(input int n);
    text_word_t w;
    repeat (n) begin
      if (text_q.size() == 0) make_text();
      if ($urandom_range(299) == 0) drain_lines(0);
      w = text_q.pop_front();
      send_byte(w.b, w.last);
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = 32'd0;
    in_valid       = 1'b0;
    in_text_byte   = 8'd0;
    in_end_of_text = 1'b0;
    out_stall      = 1'b0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    idle_cycles    = 0;
    n_widths       = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full line with an absorbed escape and CR LF, a filling tab, a lone
    // carriage return, and a text that ends on a lead byte.
    cfg_write(8'd4);
    send_str(": ab\033[m\015\n", 1'b0);
    send_str("\t\015x", 1'b0);
    send_str("\244", 1'b1);
    // Narrowest lines: text ending inside an absorbed escape, lone carriage
    // return at the end, a lead byte that must join the carriage return
    // line, and a tab wider than the line.
    cfg_write(8'd2);
    send_str("ab\033[2", 1'b1);
    send_str("ab\015", 1'b1);
    send_str("ab\015\300", 1'b1);
    send_str("\t", 1'b1);
    // Width shrinks while a line is half full.
    cfg_write(8'd8);
    send_str("ab", 1'b0);
    cfg_write(8'd3);
    send_str("\tx", 1'b1);

    for (int mix = 0; mix < 4; mix++) begin
      src_idle_pct  = (mix == 1) ? 74 : (mix == 3) ? 33 : 0;
      snk_stall_pct = (mix == 2) ? 74 : (mix == 3) ? 33 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        cfg_write(pick_width(mix * 4 + seg));
        run_segment(SEG_WORDS);
      end
    end

    drain_lines(SETTLE_CYCLES + 4);
    $display("Checked %0d lines from %0d text words over %0d width settings, %0d mismatches.",
             sb.n_checked, sb.n_words, n_widths, sb.n_fail);
    $display("The run included width changes mid-line and four idle and stall mixes.");
    if (sb.n_fail == 0 && sb.lines_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
